@@ hdl/fractional_delay_line_assert.svh @@
// ---------------------------------------------------------------------------
// Fractional delay line assertion macros
// Shared property macros; every user has aclk and aresetn in scope.
// ---------------------------------------------------------------------------
`ifndef FRACTIONAL_DELAY_LINE_ASSERT_SVH
`define FRACTIONAL_DELAY_LINE_ASSERT_SVH

// same-cycle implication
`define FDL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FDL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fdl_pkg.sv @@
// ---------------------------------------------------------------------------
// Fractional delay line package
// Field widths, register codes and the tags passed between pipeline stages.
// ---------------------------------------------------------------------------
package fdl_pkg;

    // fixed field widths
    localparam int SAMPLE_WIDTH    = 24;
    localparam int FRAC_WIDTH      = 8;
    localparam int DELAY_WIDTH     = 18;
    localparam int LEN_REG_WIDTH   = 11;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int S_TDATA_WIDTH   = 48;
    localparam int M_TDATA_WIDTH   = 24;

    // defaults
    localparam int DEPTH_DEFAULT = 1024;
    localparam int LEN_RESET     = 1024;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_LINE_LENGTH = 2'd0,
        REG_INTERP_OFF  = 2'd1
    } cfg_reg_t;

    // address stage -> store
    typedef struct packed {
        logic valid;
        logic clamped;
    } fdl_tag_t;

    // store -> interpolator
    typedef struct packed {
        logic valid;
        logic clamped;
        logic hit0;   // first tap equals the entry written in the same cycle
        logic hit1;   // second tap equals the entry written in the same cycle
    } fdl_rd_tag_t;

endpackage

@@ hdl/fdl_addr.sv @@
// ---------------------------------------------------------------------------
// Fractional delay line address stages
// Keeps the write position, clamps the delay and forms the read position.
// ---------------------------------------------------------------------------
`include "fractional_delay_line_assert.svh"

module fdl_addr #(
    parameter int MAX_DEPTH = fdl_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fdl_pkg::SAMPLE_WIDTH-1:0]    in_sample,
    input  logic [fdl_pkg::DELAY_WIDTH-1:0]     in_delay,
    input  logic [$clog2(MAX_DEPTH+1)-1:0]      act_len,
    input  logic                                hold,
    input  logic                                dn_ready,
    output fdl_pkg::fdl_tag_t                   dn_tag,
    output logic [fdl_pkg::SAMPLE_WIDTH-1:0]    dn_sample,
    output logic [$clog2(MAX_DEPTH)-1:0]        dn_wr_addr,
    output logic [$clog2(MAX_DEPTH)-1:0]        dn_rd_addr,
    output logic [fdl_pkg::FRAC_WIDTH-1:0]      dn_frac
);
    import fdl_pkg::*;

    localparam int AW   = $clog2(MAX_DEPTH);
    localparam int LENW = $clog2(MAX_DEPTH+1);
    localparam int SPW  = LENW + FRAC_WIDTH;
    localparam int DW   = (SPW > DELAY_WIDTH) ? SPW : DELAY_WIDTH;
    localparam int PW   = SPW + 1;

    logic [AW-1:0]           wp_reg, wp_next, wp_cur;
    logic [LENW-1:0]         wp_inc;
    logic [SPW-1:0]          span;
    logic [DW-1:0]           delay_ext;
    logic                    over;
    logic [SPW-1:0]          delay_sel;
    logic                    accept;
    logic                    en_a, en_b;

    logic                    va_reg, vb_reg;
    logic                    clamped_a_reg, clamped_b_reg;
    logic [SAMPLE_WIDTH-1:0] sample_a_reg, sample_b_reg;
    logic [AW-1:0]           idx_a_reg, idx_b_reg;
    logic [SPW-1:0]          delay_a_reg;
    logic [AW-1:0]           i0_b_reg;
    logic [FRAC_WIDTH-1:0]   frac_b_reg;

    logic [PW-1:0]           idx_fx, pos_dir, pos_wrap, pos;
    logic                    neg;

    // stall chain
    assign en_b     = !vb_reg || dn_ready;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a && !hold;
    assign accept   = in_valid && in_ready;

    // write position, wrapped into the active length
    always_comb begin
        wp_cur  = (LENW'(wp_reg) >= act_len) ? '0 : wp_reg;
        wp_inc  = LENW'(wp_cur) + LENW'(1);
        wp_next = (wp_inc >= act_len) ? '0 : wp_inc[AW-1:0];
    end

    // delay clamp to the line span
    assign span      = {act_len, {FRAC_WIDTH{1'b0}}};
    assign delay_ext = DW'(in_delay);
    assign over      = delay_ext > DW'(span);
    assign delay_sel = over ? span : SPW'(delay_ext);

    // read position = write index minus delay, wrapped by one span
    always_comb begin
        idx_fx   = PW'({idx_a_reg, {FRAC_WIDTH{1'b0}}});
        pos_dir  = idx_fx - PW'(delay_a_reg);
        pos_wrap = idx_fx + PW'(span) - PW'(delay_a_reg);
        neg      = idx_fx < PW'(delay_a_reg);
        pos      = neg ? pos_wrap : pos_dir;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (accept) begin
                wp_reg <= wp_next;
            end
            if (en_a) begin
                va_reg <= accept;
            end
            if (en_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_a_reg  <= in_sample;
            idx_a_reg     <= wp_cur;
            delay_a_reg   <= delay_sel;
            clamped_a_reg <= over;
        end
        if (en_b && va_reg) begin
            sample_b_reg  <= sample_a_reg;
            idx_b_reg     <= idx_a_reg;
            clamped_b_reg <= clamped_a_reg;
            i0_b_reg      <= pos[FRAC_WIDTH +: AW];
            frac_b_reg    <= pos[FRAC_WIDTH-1:0];
        end
    end

    assign dn_tag.valid   = vb_reg;
    assign dn_tag.clamped = clamped_b_reg;
    assign dn_sample      = sample_b_reg;
    assign dn_wr_addr     = idx_b_reg;
    assign dn_rd_addr     = i0_b_reg;
    assign dn_frac        = frac_b_reg;

    // checks
    `FDL_ASSERT_IMPL(a_write_pos_in_line, va_reg, LENW'(idx_a_reg) < act_len, "write position beyond line length")

endmodule

@@ hdl/fdl_store.sv @@
// ---------------------------------------------------------------------------
// Fractional delay line sample store
// One-write, two-read memory with same-cycle forwarding flags and a
// clearing pass after reset.
// ---------------------------------------------------------------------------
`include "fractional_delay_line_assert.svh"

module fdl_store #(
    parameter int MAX_DEPTH = fdl_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [$clog2(MAX_DEPTH+1)-1:0]      act_len,
    input  fdl_pkg::fdl_tag_t                   up_tag,
    input  logic [fdl_pkg::SAMPLE_WIDTH-1:0]    up_sample,
    input  logic [$clog2(MAX_DEPTH)-1:0]        up_wr_addr,
    input  logic [$clog2(MAX_DEPTH)-1:0]        up_rd_addr,
    input  logic [fdl_pkg::FRAC_WIDTH-1:0]      up_frac,
    output logic                                up_ready,
    input  logic                                dn_ready,
    output fdl_pkg::fdl_rd_tag_t                dn_tag,
    output logic [fdl_pkg::SAMPLE_WIDTH-1:0]    dn_rd0,
    output logic [fdl_pkg::SAMPLE_WIDTH-1:0]    dn_rd1,
    output logic [fdl_pkg::SAMPLE_WIDTH-1:0]    dn_sample,
    output logic [fdl_pkg::FRAC_WIDTH-1:0]      dn_frac,
    output logic                                clr_busy
);
    import fdl_pkg::*;

    localparam int AW   = $clog2(MAX_DEPTH);
    localparam int LENW = $clog2(MAX_DEPTH+1);

    logic [SAMPLE_WIDTH-1:0] store_mem [MAX_DEPTH];

    logic                    clr_busy_reg, clr_busy_next;
    logic [AW-1:0]           clr_cnt_reg, clr_cnt_next;
    fdl_rd_tag_t             tag_reg;
    logic [SAMPLE_WIDTH-1:0] rd0_reg, rd1_reg, sample_reg;
    logic [FRAC_WIDTH-1:0]   frac_reg;

    logic                    up_fire;
    logic [LENW-1:0]         len_m1;
    logic [AW-1:0]           rd_addr1;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [SAMPLE_WIDTH-1:0] mem_wdata;

    assign up_ready = !tag_reg.valid || dn_ready;
    assign up_fire  = up_tag.valid && up_ready;

    // second tap: next entry, wrapping to entry 0 past the last one in use
    assign len_m1   = act_len - LENW'(1);
    assign rd_addr1 = (LENW'(up_rd_addr) == len_m1) ? '0 : up_rd_addr + AW'(1);

    // write port: clearing pass or the new sample
    always_comb begin
        mem_we    = clr_busy_reg || up_fire;
        mem_waddr = clr_busy_reg ? clr_cnt_reg : up_wr_addr;
        mem_wdata = clr_busy_reg ? '0 : up_sample;
    end

    // memory, read-before-write
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (up_fire) begin
            rd0_reg <= store_mem[up_rd_addr];
            rd1_reg <= store_mem[rd_addr1];
        end
    end

    // clearing sweep after reset
    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(MAX_DEPTH-1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            tag_reg      <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
            if (up_ready) begin
                tag_reg.valid   <= up_tag.valid;
                tag_reg.clamped <= up_tag.clamped;
                tag_reg.hit0    <= up_rd_addr == up_wr_addr;
                tag_reg.hit1    <= rd_addr1 == up_wr_addr;
            end
        end
    end

    // payload carried beside the read data
    always_ff @(posedge aclk) begin
        if (up_fire) begin
            sample_reg <= up_sample;
            frac_reg   <= up_frac;
        end
    end

    assign dn_tag    = tag_reg;
    assign dn_rd0    = rd0_reg;
    assign dn_rd1    = rd1_reg;
    assign dn_sample = sample_reg;
    assign dn_frac   = frac_reg;
    assign clr_busy  = clr_busy_reg;

    // checks
    `FDL_ASSERT_IMPL(a_no_item_in_clear, clr_busy_reg, !up_tag.valid, "word reached the store during clearing")
    `FDL_ASSERT_IMPL(a_taps_distinct, up_fire && (act_len != LENW'(1)), rd_addr1 != up_rd_addr, "interpolation taps collide")

endmodule

@@ hdl/fdl_interp.sv @@
// ---------------------------------------------------------------------------
// Fractional delay line interpolator
// Resolves forwarding, interpolates linearly and holds the output word.
// ---------------------------------------------------------------------------
module fdl_interp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                interp_off,
    input  fdl_pkg::fdl_rd_tag_t                up_tag,
    input  logic [fdl_pkg::SAMPLE_WIDTH-1:0]    up_rd0,
    input  logic [fdl_pkg::SAMPLE_WIDTH-1:0]    up_rd1,
    input  logic [fdl_pkg::SAMPLE_WIDTH-1:0]    up_sample,
    input  logic [fdl_pkg::FRAC_WIDTH-1:0]      up_frac,
    output logic                                up_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fdl_pkg::M_TDATA_WIDTH-1:0]   m_tdata,
    output logic [0:0]                          m_tuser
);
    import fdl_pkg::*;

    localparam int PRW        = SAMPLE_WIDTH + FRAC_WIDTH + 2;
    localparam int ROUND_HALF = 1 << (FRAC_WIDTH - 1);

    logic                           en_e, en_o;
    logic signed [SAMPLE_WIDTH-1:0] s0, s1;
    logic signed [SAMPLE_WIDTH:0]   dif;
    logic signed [FRAC_WIDTH:0]     frac_s;
    logic signed [PRW-1:0]          prod;

    logic                           ve_reg, clamped_e_reg;
    logic signed [SAMPLE_WIDTH-1:0] s0_e_reg;
    logic signed [PRW-1:0]          prod_e_reg;

    logic signed [PRW-1:0]          acc;
    logic [SAMPLE_WIDTH+1:0]        res_full;
    logic [SAMPLE_WIDTH-1:0]        res;

    logic                           out_valid_reg;
    logic [SAMPLE_WIDTH-1:0]        out_data_reg;
    logic                           out_user_reg;

    assign en_o     = !out_valid_reg || m_tready;
    assign en_e     = !ve_reg || en_o;
    assign up_ready = en_e;

    // taps with same-cycle write forwarded, then (s1 - s0) * frac
    always_comb begin
        s0     = up_tag.hit0 ? up_sample : up_rd0;
        s1     = up_tag.hit1 ? up_sample : up_rd1;
        dif    = s1 - s0;
        frac_s = signed'({1'b0, up_frac});
        prod   = dif * frac_s;
    end

    // s0 + floor((dif * frac + half) / 2^F)
    always_comb begin
        acc      = prod_e_reg + PRW'(ROUND_HALF);
        res_full = (SAMPLE_WIDTH+2)'(s0_e_reg) + acc[PRW-1:FRAC_WIDTH];
        res      = interp_off ? s0_e_reg : res_full[SAMPLE_WIDTH-1:0];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en_e) begin
                ve_reg <= up_tag.valid;
            end
            if (en_o) begin
                out_valid_reg <= ve_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en_e && up_tag.valid) begin
            s0_e_reg      <= s0;
            prod_e_reg    <= prod;
            clamped_e_reg <= up_tag.clamped;
        end
        if (en_o && ve_reg) begin
            out_data_reg <= res;
            out_user_reg <= clamped_e_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

@@ hdl/fractional_delay_line.sv @@
// ---------------------------------------------------------------------------
// Fractional delay line
// Circular delay line with fractional read position and linear
// interpolation between adjacent entries.
// ---------------------------------------------------------------------------
//  channel | ports           | contents
//  --------+-----------------+-------------------------------------------
//  input   | s_t*            | sample_in, delay_amount (8 fraction bits)
//  output  | m_t*            | sample_out; tuser = delay_clamped
//  config  | cfg_*           | 0: line_length, 1: interp_off
//
//  One word per cycle sustained while m_tready is high; the store's write port
//  and two read ports serve one word each cycle. A word passes the address,
//  store and interpolator registers before m_tvalid. After reset a clearing
//  pass zeroes the store; s_tready stays low meanwhile, configuration writes
//  are taken. m_tready low fills the five pipeline stages, then s_tready drops.
// ---------------------------------------------------------------------------
`include "fractional_delay_line_assert.svh"

module fractional_delay_line #(
    parameter int MAX_DEPTH = fdl_pkg::DEPTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // [23:0] sample_in, [41:24] delay_amount, [47:42] zero
    input  logic [fdl_pkg::S_TDATA_WIDTH-1:0]     s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [23:0] sample_out
    output logic [fdl_pkg::M_TDATA_WIDTH-1:0]     m_tdata,
    // [0] delay_clamped
    output logic [0:0]                            m_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_wr_en,
    input  logic [fdl_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [fdl_pkg::LEN_REG_WIDTH-1:0]     cfg_data
);
    import fdl_pkg::*;

    localparam int AW      = $clog2(MAX_DEPTH);
    localparam int LENW    = $clog2(MAX_DEPTH+1);
    localparam int LEN_RST = (LEN_RESET > MAX_DEPTH) ? MAX_DEPTH : LEN_RESET;

    logic [LENW-1:0]         act_len_reg, act_len_next;
    logic                    interp_off_reg, interp_off_next;
    logic [31:0]             len_sel;

    fdl_tag_t                a_tag;
    logic [SAMPLE_WIDTH-1:0] a_sample;
    logic [AW-1:0]           a_wr_addr, a_rd_addr;
    logic [FRAC_WIDTH-1:0]   a_frac;
    logic                    st_ready;

    fdl_rd_tag_t             st_tag;
    logic [SAMPLE_WIDTH-1:0] st_rd0, st_rd1, st_sample;
    logic [FRAC_WIDTH-1:0]   st_frac;
    logic                    ip_ready;
    logic                    clr_busy;

    // configuration registers; length held already limited to 1..MAX_DEPTH
    always_comb begin
        len_sel = 32'(cfg_data);
        if (cfg_data == '0) begin
            len_sel = 32'd1;
        end else if (32'(cfg_data) > 32'(MAX_DEPTH)) begin
            len_sel = 32'(MAX_DEPTH);
        end
        act_len_next    = act_len_reg;
        interp_off_next = interp_off_reg;
        if (cfg_wr_en && (cfg_index == REG_LINE_LENGTH)) begin
            act_len_next = len_sel[LENW-1:0];
        end
        if (cfg_wr_en && (cfg_index == REG_INTERP_OFF)) begin
            interp_off_next = cfg_data[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_len_reg    <= LENW'(LEN_RST);
            interp_off_reg <= 1'b0;
        end else begin
            act_len_reg    <= act_len_next;
            interp_off_reg <= interp_off_next;
        end
    end

    // position stages
    fdl_addr #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_addr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata[SAMPLE_WIDTH-1:0]),
        .in_delay   (s_tdata[SAMPLE_WIDTH +: DELAY_WIDTH]),
        .act_len    (act_len_reg),
        .hold       (clr_busy),
        .dn_ready   (st_ready),
        .dn_tag     (a_tag),
        .dn_sample  (a_sample),
        .dn_wr_addr (a_wr_addr),
        .dn_rd_addr (a_rd_addr),
        .dn_frac    (a_frac)
    );

    // sample memory
    fdl_store #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .act_len    (act_len_reg),
        .up_tag     (a_tag),
        .up_sample  (a_sample),
        .up_wr_addr (a_wr_addr),
        .up_rd_addr (a_rd_addr),
        .up_frac    (a_frac),
        .up_ready   (st_ready),
        .dn_ready   (ip_ready),
        .dn_tag     (st_tag),
        .dn_rd0     (st_rd0),
        .dn_rd1     (st_rd1),
        .dn_sample  (st_sample),
        .dn_frac    (st_frac),
        .clr_busy   (clr_busy)
    );

    // interpolation and output word
    fdl_interp u_interp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .interp_off (interp_off_reg),
        .up_tag     (st_tag),
        .up_rd0     (st_rd0),
        .up_rd1     (st_rd1),
        .up_sample  (st_sample),
        .up_frac    (st_frac),
        .up_ready   (ip_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // checks
    `FDL_ASSERT_IMPL(a_closed_while_clearing, clr_busy, !s_tready, "input open during clearing pass")

endmodule
